[src/mhtq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_pkg
// shared types and codes of the min-heap timer queue
// ----------------------------------------------------------------------------
package mhtq_pkg;

	localparam int MAX_FIRE = 32;   // fired results per tick request
	localparam int FIRE_W   = 6;
	localparam int MAX_HND  = 32;   // handle field is five bits

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_FIRED  = 2'd2;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_FULL        = 2'd2;
	localparam logic [1:0] ST_NO_HANDLE   = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic        bad_timeout;
		logic [31:0] now;
		logic [30:0] timeout;
		logic [4:0]  handle;
		logic [31:0] tag;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [4:0]  handle;
		logic [31:0] tag;
		logic [30:0] period;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [32:0] expiry;
		logic [4:0]  handle;
	} heap_ent_t;

endpackage

[src/mhtq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mhtq_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[src/mhtq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_front
// accepts requests, classifies them and queues them for the heap engine
// ----------------------------------------------------------------------------
module mhtq_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [103:0]     s_axis_tdata,
	input  logic [1:0]       s_axis_tuser,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output mhtq_pkg::cmd_t   cmd
);

	mhtq_pkg::cmd_t q_q [2];
	mhtq_pkg::cmd_t in_cmd;
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           enq;
	logic           deq;

	assign s_axis_tready = (cnt_q != 2'd2);
	assign cmd_valid     = (cnt_q != 2'd0);
	assign cmd           = q_q[rd_q];
	assign deq           = cmd_valid && cmd_ready;
	// unused operation code produces nothing, so it never enters the queue
	assign enq = s_axis_tvalid && s_axis_tready && (s_axis_tuser != mhtq_pkg::OP_NONE);

	always_comb begin
		in_cmd.op          = s_axis_tuser;
		in_cmd.now         = s_axis_tdata[31:0];
		in_cmd.timeout     = s_axis_tdata[62:32];
		in_cmd.handle      = s_axis_tdata[67:63];
		in_cmd.tag         = s_axis_tdata[99:68];
		in_cmd.bad_timeout = (s_axis_tdata[62:32] == 31'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) begin
				wr_q <= ~wr_q;
			end
			if (deq) begin
				rd_q <= ~rd_q;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!enq && deq) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wr_q] <= in_cmd;
		end
	end

endmodule

[src/mhtq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_back
// heap engine: sift-up on add, disarm on cancel, pop and sift-down on tick, result register
// ----------------------------------------------------------------------------
module mhtq_back #(
	parameter int CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  mhtq_pkg::cmd_t   cmd,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [71:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,
	output logic             m_axis_tlast
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int DW  = AW + 2;
	localparam int NH  = (CAPACITY < mhtq_pkg::MAX_HND) ? CAPACITY : mhtq_pkg::MAX_HND;
	localparam int NHW = $clog2(NH);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EMIT = 4'd1;
	localparam logic [3:0] S_UP   = 4'd2;
	localparam logic [3:0] S_UPW  = 4'd3;
	localparam logic [3:0] S_POP  = 4'd4;
	localparam logic [3:0] S_POPW = 4'd5;
	localparam logic [3:0] S_LAST = 4'd6;
	localparam logic [3:0] S_DN   = 4'd7;
	localparam logic [3:0] S_DNW  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]                   state_q;
	logic [CW-1:0]                count_q;
	logic [NH-1:0]                armed_q;
	logic [NH-1:0]                inuse_q;
	logic [31:0]                  tag_q [NH];
	logic [30:0]                  per_q [NH];
	logic [AW-1:0]                pos_q;
	mhtq_pkg::heap_ent_t          ent_q;
	mhtq_pkg::res_t               res_q;
	mhtq_pkg::res_t               pend_q;
	logic                         pend_v_q;
	logic [mhtq_pkg::FIRE_W-1:0]  nfire_q;
	logic [31:0]                  now_q;
	logic                         out_v_q;
	mhtq_pkg::res_t               out_q;

	// heap ram signals
	logic                 we;
	logic [AW-1:0]        waddr;
	mhtq_pkg::heap_ent_t  wdata;
	logic                 re_a;
	logic [AW-1:0]        raddr_a;
	mhtq_pkg::heap_ent_t  rd_a;
	logic                 re_b;
	logic [AW-1:0]        raddr_b;
	mhtq_pkg::heap_ent_t  rd_b;

	logic                 out_free;
	logic                 free_found;
	logic [4:0]           free_h;
	logic                 full;
	logic                 add_go;
	logic [AW-1:0]        parent;
	logic                 up_stop;
	logic [NHW-1:0]       pop_h;
	logic                 due;
	logic                 fire;
	logic                 pop_blocked;
	logic [DW-1:0]        c_a;
	logic [DW-1:0]        c_b;
	logic                 leaf;
	logic                 pick_b;
	mhtq_pkg::heap_ent_t  child;
	logic [DW-1:0]        ci;
	logic                 dn_stop;
	logic                 cnt_hit;
	logic                 push;
	mhtq_pkg::res_t       push_res;

	mhtq_ram #(
		.WIDTH($bits(mhtq_pkg::heap_ent_t)),
		.DEPTH(CAPACITY)
	) u_heap (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re_a    (re_a),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.re_b    (re_b),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	assign out_free  = !out_v_q || m_axis_tready;
	assign cmd_ready = (state_q == S_IDLE);

	// lowest free handle
	always_comb begin
		free_found = 1'b0;
		free_h     = 5'd0;
		for (int i = NH - 1; i >= 0; i--) begin
			if (!inuse_q[i]) begin
				free_found = 1'b1;
				free_h     = 5'(i);
			end
		end
	end

	assign full   = (count_q >= CW'(CAPACITY)) || !free_found;
	assign add_go = cmd_valid && cmd_ready && (cmd.op == mhtq_pkg::OP_ADD) &&
		!cmd.bad_timeout && !full;

	assign parent  = (pos_q - AW'(1)) >> 1;
	assign up_stop = (rd_a.expiry <= ent_q.expiry);

	assign pop_h       = rd_a.handle[NHW-1:0];
	assign due         = (rd_a.expiry <= {1'b0, now_q});
	assign fire        = armed_q[pop_h];
	assign pop_blocked = fire && pend_v_q && !out_free;
	assign cnt_hit     = (count_q == CW'(0)) || (nfire_q == mhtq_pkg::FIRE_W'(mhtq_pkg::MAX_FIRE));

	assign c_a     = {1'b0, pos_q, 1'b1};
	assign c_b     = c_a + DW'(1);
	assign leaf    = (c_a >= DW'(count_q));
	assign pick_b  = (c_b < DW'(count_q)) && (rd_b.expiry < rd_a.expiry);
	assign child   = pick_b ? rd_b : rd_a;
	assign ci      = pick_b ? c_b : c_a;
	assign dn_stop = !(child.expiry < ent_q.expiry);

	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = ent_q;
		re_a    = 1'b0;
		raddr_a = '0;
		re_b    = 1'b0;
		raddr_b = '0;
		case (state_q)
			S_UP: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					re_a    = 1'b1;
					raddr_a = parent;
				end
			end
			S_UPW: begin
				we    = 1'b1;
				wdata = up_stop ? ent_q : rd_a;
			end
			S_POP: begin
				re_a = !cnt_hit;
			end
			S_POPW: begin
				// fetch the tail entry that moves to the root
				if (due && !pop_blocked && (count_q > CW'(1))) begin
					re_a    = 1'b1;
					raddr_a = AW'(count_q - CW'(1));
				end
			end
			S_DN: begin
				if (leaf) begin
					we = 1'b1;
				end else begin
					re_a    = 1'b1;
					raddr_a = c_a[AW-1:0];
					re_b    = 1'b1;
					raddr_b = c_b[AW-1:0];
				end
			end
			S_DNW: begin
				we    = 1'b1;
				wdata = dn_stop ? ent_q : child;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push     = 1'b0;
		push_res = res_q;
		case (state_q)
			S_EMIT: begin
				push          = out_free;
				push_res.last = 1'b1;
			end
			S_POPW: begin
				// a later fire proves the held one was not the final result
				push     = due && fire && pend_v_q && out_free;
				push_res = pend_q;
			end
			S_FIN: begin
				push          = pend_v_q && out_free;
				push_res      = pend_q;
				push_res.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			armed_q  <= '0;
			inuse_q  <= '0;
			pos_q    <= '0;
			ent_q    <= '0;
			res_q    <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			nfire_q  <= '0;
			now_q    <= '0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			if (push) begin
				out_v_q <= 1'b1;
				out_q   <= push_res;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					// tag and period of acknowledges stay zero from reset
					if (cmd_valid) begin
						case (cmd.op)
							mhtq_pkg::OP_ADD: begin
								res_q.kind <= mhtq_pkg::KIND_ADD;
								if (cmd.bad_timeout) begin
									res_q.status <= mhtq_pkg::ST_BAD_TIMEOUT;
									res_q.handle <= '0;
									state_q      <= S_EMIT;
								end else if (full) begin
									res_q.status <= mhtq_pkg::ST_FULL;
									res_q.handle <= '0;
									state_q      <= S_EMIT;
								end else begin
									res_q.status                <= mhtq_pkg::ST_OK;
									res_q.handle                <= free_h;
									armed_q[free_h[NHW-1:0]]    <= 1'b1;
									inuse_q[free_h[NHW-1:0]]    <= 1'b1;
									ent_q.expiry <= {1'b0, cmd.now} + {2'b00, cmd.timeout};
									ent_q.handle <= free_h;
									pos_q        <= AW'(count_q);
									count_q      <= count_q + CW'(1);
									state_q      <= S_UP;
								end
							end
							mhtq_pkg::OP_CANCEL: begin
								res_q.kind   <= mhtq_pkg::KIND_CANCEL;
								res_q.handle <= cmd.handle;
								state_q      <= S_EMIT;
								if (({1'b0, cmd.handle} < 6'(NH)) &&
									inuse_q[cmd.handle[NHW-1:0]]) begin
									res_q.status                 <= mhtq_pkg::ST_OK;
									armed_q[cmd.handle[NHW-1:0]] <= 1'b0;
								end else begin
									res_q.status <= mhtq_pkg::ST_NO_HANDLE;
								end
							end
							mhtq_pkg::OP_TICK: begin
								now_q    <= cmd.now;
								nfire_q  <= '0;
								pend_v_q <= 1'b0;
								state_q  <= S_POP;
							end
							default: begin
							end
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_UP: begin
					state_q <= (pos_q == '0) ? S_EMIT : S_UPW;
				end
				S_UPW: begin
					if (up_stop) begin
						state_q <= S_EMIT;
					end else begin
						pos_q   <= parent;
						state_q <= S_UP;
					end
				end
				S_POP: begin
					state_q <= cnt_hit ? S_FIN : S_POPW;
				end
				S_POPW: begin
					if (!due) begin
						state_q <= S_FIN;
					end else if (!pop_blocked) begin
						if (fire) begin
							pend_q.kind   <= mhtq_pkg::KIND_FIRED;
							pend_q.status <= mhtq_pkg::ST_OK;
							pend_q.handle <= rd_a.handle;
							pend_q.tag    <= tag_q[pop_h];
							pend_q.period <= per_q[pop_h];
							pend_q.last   <= 1'b0;
							pend_v_q      <= 1'b1;
							nfire_q       <= nfire_q + mhtq_pkg::FIRE_W'(1);
						end
						armed_q[pop_h] <= 1'b0;
						inuse_q[pop_h] <= 1'b0;
						count_q        <= count_q - CW'(1);
						state_q        <= (count_q > CW'(1)) ? S_LAST : S_POP;
					end
				end
				S_LAST: begin
					ent_q   <= rd_a;
					pos_q   <= '0;
					state_q <= S_DN;
				end
				S_DN: begin
					state_q <= leaf ? S_POP : S_DNW;
				end
				S_DNW: begin
					if (dn_stop) begin
						state_q <= S_POP;
					end else begin
						pos_q   <= ci[AW-1:0];
						state_q <= S_DN;
					end
				end
				S_FIN: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (add_go) begin
			tag_q[free_h[NHW-1:0]] <= cmd.tag;
			per_q[free_h[NHW-1:0]] <= cmd.timeout;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {2'b00, out_q.period, out_q.tag, out_q.handle, out_q.status};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

endmodule

[src/min_heap_timer_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// timer queue kept as a binary min-heap ordered by expiry time
// ----------------------------------------------------------------------------
// Requests are queued two deep in front of a heap engine that works on one
// request at a time, with the heap in a ram of one write and two registered
// read ports. An add sifts the new entry up the heap and a cancel only
// disarms its handle; a tick pops due entries from the root and sifts the
// tail entry down in their place, each level costing one ram read and one
// compare. Up to 32 fired results come out per tick, the last one flagged
// with tlast; add and cancel give one acknowledge each. A full result
// register can stall the engine.
module min_heap_timer_queue #(
	parameter int CAPACITY = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [103:0]  s_axis_tdata,   // now, timeout, handle, tag
	input  logic [1:0]    s_axis_tuser,   // func
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [71:0]   m_axis_tdata,   // status, timer_handle, user_tag, timer_period
	output logic [1:0]    m_axis_tuser,   // kind
	output logic          m_axis_tlast
);

	logic           cmd_valid;
	logic           cmd_ready;
	mhtq_pkg::cmd_t cmd;

	mhtq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	mhtq_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// acknowledges are always single results
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != mhtq_pkg::KIND_FIRED) |-> m_axis_tlast)
		else $error("acknowledge without tlast");

	// a fired timer always reports ok
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == mhtq_pkg::KIND_FIRED) |->
		(m_axis_tdata[1:0] == mhtq_pkg::ST_OK))
		else $error("fired result with bad status");

	// acknowledges carry no tag or period
	a_ack_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != mhtq_pkg::KIND_FIRED) |->
		(m_axis_tdata[71:7] == 65'd0))
		else $error("acknowledge carries tag or period");

endmodule
